// File: hdl/sxfe_pkg.sv
// ----------------------------------------------------------------------------
// sxfe_pkg
// Shared types and constants for the sprite XOR framebuffer engine.
// ----------------------------------------------------------------------------
package sxfe_pkg;

  localparam int MEM_DEPTH    = 4096;
  localparam int FRAME_WIDTH  = 64;
  localparam int FRAME_HEIGHT = 32;

  localparam int COL_W  = $clog2(FRAME_WIDTH);
  localparam int ROW_W  = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W = 12;
  localparam int CMD_W  = 3;

  localparam logic [CMD_W-1:0] CMD_MEM_WRITE = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MEM_READ  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DRAW      = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROW_READ  = 3'd4;

  typedef logic [FRAME_WIDTH-1:0] row_t;
  typedef logic [7:0]             byte_t;

  // framebuffer port control
  typedef struct packed {
    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    logic             clear;
  } fb_ctrl_t;

endpackage

// File: hdl/sprite_xor_framebuffer_engine_core.sv
// ----------------------------------------------------------------------------
// sprite_xor_framebuffer_engine_core
// Memory write, frame clear, unused commands and a sprite draw with no row to
// draw complete with no sequencer state; memory read and frame row read go
// through the registered memory read and ST_RDM or ST_RDF; sprite draw runs
// n rows (1 to 15) through the single shift/XOR unit, one row per cycle.
// Throughput: one word at a time; busy stays high until the result strobe.
// Reset (rst, synchronous) clears the framebuffer; sprite memory
// is undefined until written. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module sprite_xor_framebuffer_engine_core #(
  parameter int MEM_DEPTH = sxfe_pkg::MEM_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [sxfe_pkg::CMD_W-1:0]    command,
  input  logic [sxfe_pkg::ADDR_W-1:0]   address,
  input  logic [7:0]                    write_data,
  input  logic [7:0]                    sprite_x,
  input  logic [7:0]                    sprite_y,
  input  logic [3:0]                    sprite_height,
  input  logic [4:0]                    frame_row,
  output logic                          done,
  output logic [7:0]                    read_data,
  output logic                          collision,
  output logic [63:0]                   row_pixels
);

  // depth is taken as a power of two; addresses wrap on the low bits
  localparam int AW    = $clog2(MEM_DEPTH);
  localparam int COL_W = sxfe_pkg::COL_W;
  localparam int ROW_W = sxfe_pkg::ROW_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_RDM  = 2'd2;
  localparam logic [1:0] ST_RDF  = 2'd3;

  logic [1:0]                 state;
  logic [sxfe_pkg::CMD_W-1:0] cmd_q;
  logic [AW-1:0]              ptr;
  logic [ROW_W-1:0]           rd_row;
  logic [ROW_W-1:0]           wr_row;
  logic [3:0]                 left;
  logic                       pend;
  logic                       hit;
  logic [COL_W-1:0]           col;

  logic                       accept;
  logic [AW-1:0]              addr_w;
  logic [ROW_W-1:0]           y_w;
  logic [ROW_W:0]             rows_left;
  logic [3:0]                 n_rows;

  sxfe_pkg::fb_ctrl_t         fb_ctrl;
  sxfe_pkg::row_t             fb_rd_data;
  sxfe_pkg::row_t             new_row;
  sxfe_pkg::byte_t            spr_rd_data;
  logic                       spr_rd_en;
  logic [AW-1:0]              spr_rd_addr;
  logic                       unit_hit;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign addr_w = AW'(address);
  assign y_w    = sprite_y[ROW_W-1:0];

  // rows that fit above the bottom edge
  assign rows_left = (ROW_W+1)'(sxfe_pkg::FRAME_HEIGHT) - {1'b0, y_w};
  assign n_rows    = ({{(ROW_W-3){1'b0}}, sprite_height} < rows_left) ?
                     sprite_height : rows_left[3:0];

  // memory port selection
  always_comb begin
    spr_rd_en       = 1'b0;
    spr_rd_addr     = ptr;
    fb_ctrl         = '0;
    fb_ctrl.wr_addr = wr_row;
    fb_ctrl.rd_addr = rd_row;
    if (accept) begin
      case (command)
        sxfe_pkg::CMD_MEM_READ: begin
          spr_rd_en   = 1'b1;
          spr_rd_addr = addr_w;
        end
        sxfe_pkg::CMD_CLEAR: begin
          fb_ctrl.clear = 1'b1;
        end
        sxfe_pkg::CMD_ROW_READ: begin
          fb_ctrl.rd_en   = 1'b1;
          fb_ctrl.rd_addr = frame_row[ROW_W-1:0];
        end
        default: begin
        end
      endcase
    end else if (state == ST_DRAW) begin
      spr_rd_en     = (left != 4'd0);
      fb_ctrl.rd_en = (left != 4'd0);
      fb_ctrl.wr_en = pend;
    end
  end

  sxfe_sprite_mem #(
    .MEM_DEPTH (MEM_DEPTH),
    .AW        (AW)
  ) u_sprite_mem (
    .clk     (clk),
    .wr_en   (accept && (command == sxfe_pkg::CMD_MEM_WRITE)),
    .wr_addr (addr_w),
    .wr_data (write_data),
    .rd_en   (spr_rd_en),
    .rd_addr (spr_rd_addr),
    .rd_data (spr_rd_data)
  );

  sxfe_frame_mem u_frame_mem (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (fb_ctrl),
    .wr_data (new_row),
    .rd_data (fb_rd_data)
  );

  sxfe_xor_unit u_xor (
    .sprite_byte (spr_rd_data),
    .col         (col),
    .old_row     (fb_rd_data),
    .new_row     (new_row),
    .hit         (unit_hit)
  );

  // sequencer and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
      left  <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              sxfe_pkg::CMD_MEM_READ: begin
                state <= ST_RDM;
              end
              sxfe_pkg::CMD_ROW_READ: begin
                state <= ST_RDF;
              end
              sxfe_pkg::CMD_DRAW: begin
                left <= n_rows;
                pend <= 1'b0;
                hit  <= 1'b0;
                if (n_rows != 4'd0) begin
                  state <= ST_DRAW;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_DRAW: begin
          if (left != 4'd0) begin
            left <= left - 4'd1;
          end
          pend <= (left != 4'd0);
          if (pend) begin
            hit <= hit | unit_hit;
          end
          if (left == 4'd0) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
        end
        ST_RDM: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        ST_RDF: begin
          state <= ST_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // draw datapath and result word
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q      <= command;
      ptr        <= addr_w;
      rd_row     <= y_w;
      wr_row     <= y_w;
      col        <= sprite_x[COL_W-1:0];
      read_data  <= '0;
      collision  <= 1'b0;
      row_pixels <= '0;
    end else begin
      case (state)
        ST_DRAW: begin
          if (left != 4'd0) begin
            ptr    <= ptr + AW'(1);
            rd_row <= rd_row + ROW_W'(1);
          end
          if (pend) begin
            wr_row <= wr_row + ROW_W'(1);
          end
          if (left == 4'd0) begin
            collision <= hit | (pend & unit_hit);
          end
        end
        ST_RDM: begin
          read_data <= spr_rd_data;
        end
        ST_RDF: begin
          row_pixels <= fb_rd_data;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_draw_progress: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAW) |-> (left != 4'd0 || pend))
    else $error("draw sequencer stalled with nothing to do");

  a_coll_draw: assert property (@(posedge clk) disable iff (rst)
    (done && collision) |-> (cmd_q == sxfe_pkg::CMD_DRAW))
    else $error("collision reported for a non-draw command");

  a_rd_mem: assert property (@(posedge clk) disable iff (rst)
    (done && read_data != 8'd0) |-> (cmd_q == sxfe_pkg::CMD_MEM_READ))
    else $error("read data returned for a non-read command");

  a_fb_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (fb_ctrl.rd_en && fb_ctrl.wr_en) |-> (fb_ctrl.rd_addr != fb_ctrl.wr_addr))
    else $error("framebuffer read and write to the same row");
`endif

endmodule

// File: hdl/sxfe_sprite_mem.sv
// ----------------------------------------------------------------------------
// sxfe_sprite_mem
// Byte-wide program and sprite store, one write and one registered read port.
// ----------------------------------------------------------------------------
module sxfe_sprite_mem #(
  parameter int MEM_DEPTH = sxfe_pkg::MEM_DEPTH,
  parameter int AW        = $clog2(MEM_DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  sxfe_pkg::byte_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output sxfe_pkg::byte_t rd_data
);

  sxfe_pkg::byte_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/sxfe_frame_mem.sv
// ----------------------------------------------------------------------------
// sxfe_frame_mem
// 1bpp framebuffer, one row per entry, with per-row valid bits so that a
// frame clear or reset only has to reset the valid bits.
// ----------------------------------------------------------------------------
module sxfe_frame_mem (
  input  logic               clk,
  input  logic               rst,
  input  sxfe_pkg::fb_ctrl_t ctrl,
  input  sxfe_pkg::row_t     wr_data,
  output sxfe_pkg::row_t     rd_data
);

  sxfe_pkg::row_t                  rows [sxfe_pkg::FRAME_HEIGHT];
  logic [sxfe_pkg::FRAME_HEIGHT-1:0] valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ctrl.clear) begin
      valid <= '0;
    end else if (ctrl.wr_en) begin
      valid[ctrl.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      rows[ctrl.wr_addr] <= wr_data;
    end
  end

  // a row never written since the last clear reads as all off
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data <= valid[ctrl.rd_addr] ? rows[ctrl.rd_addr] : '0;
    end
  end

endmodule

// File: hdl/sxfe_xor_unit.sv
// ----------------------------------------------------------------------------
// sxfe_xor_unit
// Shared shift/XOR unit: places one sprite byte at column x (clipped at the
// right edge) and toggles it into a framebuffer row, flagging lit pixels hit.
// ----------------------------------------------------------------------------
module sxfe_xor_unit (
  input  sxfe_pkg::byte_t              sprite_byte,
  input  logic [sxfe_pkg::COL_W-1:0]   col,
  input  sxfe_pkg::row_t               old_row,
  output sxfe_pkg::row_t               new_row,
  output logic                         hit
);

  sxfe_pkg::row_t placed;
  sxfe_pkg::row_t mask;

  assign placed  = {sprite_byte, {(sxfe_pkg::FRAME_WIDTH-8){1'b0}}};
  // logical right shift drops bits past the right edge
  assign mask    = placed >> col;
  assign new_row = old_row ^ mask;
  assign hit     = |(old_row & mask);

endmodule
